// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the landmark associator checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/core/nla_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nla_pkg
// types and constants shared by the landmark associator modules
// ----------------------------------------------------------------------------
package nla_pkg;

    localparam int ID_W    = 16;
    localparam int COORD_W = 24;
    localparam int MAG_W   = COORD_W;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int DIST_W  = SQ_W + 1;

    // pipeline depth of the distance unit after the tap
    localparam int DRAIN_CYCLES = 3;
    localparam int DRAIN_W      = 2;

    typedef logic [ID_W-1:0]           id_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [1:0]                cmd_t;

    localparam cmd_t CMD_CLEAR = 2'd0;
    localparam cmd_t CMD_LOAD  = 2'd1;
    localparam cmd_t CMD_QUERY = 2'd2;

    typedef struct packed {
        id_t    id;
        coord_t x;
        coord_t y;
    } entry_t;

    typedef struct packed {
        id_t  nearest_id;
        logic found;
        logic load_overflow;
    } result_t;

    typedef struct packed {
        id_t  best_id;
        logic have;
    } best_t;

endpackage

// ----- rtl/core/nearest_landmark_associator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_landmark_associator
// landmark table with nearest neighbour query over a rotating chain of slots
// ----------------------------------------------------------------------------
// usage:
//   input items (command, landmark_id, point_x, point_y) are taken on
//   item_valid with item_stall low; results (nearest_id, found,
//   load_overflow) leave on result_valid and are held while result_stall.
//   clear empties the table and gives no result. load shifts the landmark
//   into the head of the chain and gives one result, with load_overflow
//   set when the table already holds MAX_LANDMARKS entries.
//   query rotates the whole chain once past a single distance unit: the
//   chain is scanned, the distance pipeline drains and the result is then
//   registered; the rotation length sets the query rate, while loads go
//   at one a cycle as long as the output register is free.
//   item_stall is high from
//   a query until its result has entered the output register, and while a
//   load result waits for a stalled output register.
//   reset empties the table; slot contents are not cleared and are never
//   read while outside the stored count. a stalled result simply holds.
// ----------------------------------------------------------------------------
module nearest_landmark_associator #(
    parameter int MAX_LANDMARKS = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  nla_pkg::cmd_t   command,
    input  nla_pkg::id_t    landmark_id,
    input  nla_pkg::coord_t point_x,
    input  nla_pkg::coord_t point_y,
    output logic            result_valid,
    input  logic            result_stall,
    output nla_pkg::id_t    nearest_id,
    output logic            found,
    output logic            load_overflow
);
    import nla_pkg::*;

    localparam int CW = $clog2(MAX_LANDMARKS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   step_reg;
    logic [DRAIN_W-1:0] drain_reg;
    logic            query_reg;
    result_t         pend_reg;
    result_t         out_reg;
    logic            out_valid_reg;
    logic            out_valid_next;
    coord_t          qx_reg;
    coord_t          qy_reg;

    entry_t          chain [MAX_LANDMARKS];
    entry_t          head_d;
    entry_t          new_entry;
    best_t           best;
    result_t         load_res;
    result_t         query_res;
    logic            accept;
    logic            out_free;
    logic            full;
    logic            scanning;
    logic            do_store;
    logic            shift_en;
    logic            tap_valid;
    logic            start;

    // handshake and control decode
    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign out_free   = !out_valid_reg || !result_stall;
    assign full       = (count_reg == CW'(MAX_LANDMARKS));
    assign scanning   = (state_reg == ST_SCAN);
    assign do_store   = accept && (command == CMD_LOAD) && !full;
    assign shift_en   = do_store || scanning;
    assign start      = accept && (command == CMD_QUERY);
    // slots beyond the count pass the tap first, the oldest entry follows
    assign tap_valid  = scanning && (step_reg >= (CW'(MAX_LANDMARKS) - count_reg));

    assign new_entry.id = landmark_id;
    assign new_entry.x  = point_x;
    assign new_entry.y  = point_y;
    assign head_d       = scanning ? chain[MAX_LANDMARKS-1] : new_entry;

    assign load_res.nearest_id    = '0;
    assign load_res.found         = 1'b0;
    assign load_res.load_overflow = full;

    assign query_res.nearest_id    = best.best_id;
    assign query_res.found         = best.have;
    assign query_res.load_overflow = 1'b0;

    // chain of landmark slots, rotating during a query
    genvar gi;
    generate
        for (gi = 0; gi < MAX_LANDMARKS; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                nla_cell u_cell (
                    .clk      (clk),
                    .shift_en (shift_en),
                    .d        (head_d),
                    .q        (chain[gi])
                );
            end
            else
            begin : g_body
                nla_cell u_cell (
                    .clk      (clk),
                    .shift_en (shift_en),
                    .d        (chain[gi-1]),
                    .q        (chain[gi])
                );
            end
        end
    endgenerate

    // distance unit at the tail of the chain
    nla_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .tap_valid (tap_valid),
        .tap       (chain[MAX_LANDMARKS-1]),
        .qx        (qx_reg),
        .qy        (qy_reg),
        .best      (best)
    );

    // output valid: set when a result is written, cleared when taken
    always_comb
    begin
        out_valid_next = out_valid_reg && result_stall;
        if (out_free && ((accept && (command == CMD_LOAD)) || (state_reg == ST_RESULT)))
        begin
            out_valid_next = 1'b1;
        end
    end

    // sequencer, table count and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            drain_reg     <= '0;
            query_reg     <= 1'b0;
            pend_reg      <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
            qx_reg        <= '0;
            qy_reg        <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (command)
                            CMD_CLEAR:
                            begin
                                count_reg <= '0;
                            end
                            CMD_LOAD:
                            begin
                                if (!full)
                                begin
                                    count_reg <= CW'(count_reg + 1'b1);
                                end
                                query_reg <= 1'b0;
                                if (out_free)
                                begin
                                    out_reg <= load_res;
                                end
                                else
                                begin
                                    pend_reg  <= load_res;
                                    state_reg <= ST_RESULT;
                                end
                            end
                            CMD_QUERY:
                            begin
                                qx_reg    <= point_x;
                                qy_reg    <= point_y;
                                step_reg  <= '0;
                                query_reg <= 1'b1;
                                state_reg <= ST_SCAN;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    step_reg <= CW'(step_reg + 1'b1);
                    if (step_reg == CW'(MAX_LANDMARKS - 1))
                    begin
                        drain_reg <= '0;
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    drain_reg <= DRAIN_W'(drain_reg + 1'b1);
                    if (drain_reg == DRAIN_W'(DRAIN_CYCLES - 1))
                    begin
                        state_reg <= ST_RESULT;
                    end
                end
                ST_RESULT:
                begin
                    if (out_free)
                    begin
                        out_reg   <= query_reg ? query_res : pend_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid  = out_valid_reg;
    assign nearest_id    = out_reg.nearest_id;
    assign found         = out_reg.found;
    assign load_overflow = out_reg.load_overflow;

endmodule

// ----- rtl/core/nla_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nla_cell
// one landmark slot of the chain, passes its entry to the next slot on shift
// ----------------------------------------------------------------------------
module nla_cell (
    input  logic            clk,
    input  logic            shift_en,
    input  nla_pkg::entry_t d,
    output nla_pkg::entry_t q
);
    import nla_pkg::*;

    entry_t entry_reg;

    // slot storage, loaded on shift from the previous slot or, at the head, from the head input
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            entry_reg <= d;
        end
    end

    assign q = entry_reg;

endmodule

// ----- rtl/core/nla_dist.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nla_dist
// pipelined squared distance unit with running minimum at the chain tap
// ----------------------------------------------------------------------------
module nla_dist (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            tap_valid,
    input  nla_pkg::entry_t tap,
    input  nla_pkg::coord_t qx,
    input  nla_pkg::coord_t qy,
    output nla_pkg::best_t  best
);
    import nla_pkg::*;

    logic [COORD_W:0] diff_x;
    logic [COORD_W:0] diff_y;
    logic [COORD_W:0] neg_x;
    logic [COORD_W:0] neg_y;
    logic [MAG_W-1:0] dx_next;
    logic [MAG_W-1:0] dy_next;

    logic [MAG_W-1:0]  dx_reg;
    logic [MAG_W-1:0]  dy_reg;
    id_t               id1_reg;
    logic              v1_reg;
    logic [SQ_W-1:0]   sqx_reg;
    logic [SQ_W-1:0]   sqy_reg;
    id_t               id2_reg;
    logic              v2_reg;
    logic [DIST_W-1:0] d_reg;
    id_t               id3_reg;
    logic              v3_reg;
    logic [DIST_W-1:0] best_d_reg;
    id_t               best_id_reg;
    logic              have_reg;

    // absolute coordinate differences, at most 2^24 - 1 so 24 bits hold them
    always_comb
    begin
        diff_x  = {qx[COORD_W-1], qx} - {tap.x[COORD_W-1], tap.x};
        diff_y  = {qy[COORD_W-1], qy} - {tap.y[COORD_W-1], tap.y};
        neg_x   = (COORD_W+1)'(~diff_x + 1'b1);
        neg_y   = (COORD_W+1)'(~diff_y + 1'b1);
        dx_next = diff_x[COORD_W] ? neg_x[MAG_W-1:0] : diff_x[MAG_W-1:0];
        dy_next = diff_y[COORD_W] ? neg_y[MAG_W-1:0] : diff_y[MAG_W-1:0];
    end

    // pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= tap_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // difference, square and sum stages
    always_ff @(posedge clk)
    begin
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        id1_reg <= tap.id;
        sqx_reg <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
        sqy_reg <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
        id2_reg <= id1_reg;
        d_reg   <= DIST_W'(sqx_reg) + DIST_W'(sqy_reg);
        id3_reg <= id2_reg;
    end

    // running minimum, strictly smaller replaces so the oldest wins a tie
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg    <= 1'b0;
            best_id_reg <= '0;
            best_d_reg  <= '0;
        end
        else if (start)
        begin
            have_reg    <= 1'b0;
            best_id_reg <= '0;
        end
        else if (v3_reg && (!have_reg || (d_reg < best_d_reg)))
        begin
            have_reg    <= 1'b1;
            best_id_reg <= id3_reg;
            best_d_reg  <= d_reg;
        end
    end

    assign best.best_id = best_id_reg;
    assign best.have    = have_reg;

endmodule

// ----- rtl/core/nla_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nla_checker
// port-level checks of the landmark associator, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nla_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            item_valid,
    input logic            item_stall,
    input nla_pkg::cmd_t   command,
    input logic            result_valid,
    input logic            result_stall,
    input nla_pkg::id_t    nearest_id,
    input logic            found,
    input logic            load_overflow
);
    import nla_pkg::*;

    // a stalled result stays offered
    `ASSERT_NEXT(a_result_held, clk, rst_n, result_valid && result_stall, result_valid)

    // no match means a zero id
    `ASSERT_IMPLY(a_empty_id, clk, rst_n, result_valid && !found, nearest_id == '0)

    // an overflow report is a load result, never a match
    `ASSERT_IMPLY(a_overflow_nofound, clk, rst_n, result_valid && load_overflow, !found)

    // a query keeps the input side busy while the chain rotates
    `ASSERT_NEXT(a_query_busy, clk, rst_n,
                 item_valid && !item_stall && (command == CMD_QUERY), item_stall)

endmodule

bind nearest_landmark_associator nla_checker u_nla_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .command       (command),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .nearest_id    (nearest_id),
    .found         (found),
    .load_overflow (load_overflow)
);

// ----- tb/nearest_landmark_associator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_landmark_associator_tb
// self-checking bench for the landmark table and nearest landmark query.
// a local table model predicts one answer per load and query; answers are
// checked in order against the result port while both handshakes see
// random gaps and one long output hold-off.
// ----------------------------------------------------------------------------
module nearest_landmark_associator_tb;

    import nla_pkg::*;

    localparam int     MAX_LANDMARKS   = 64;
    localparam int     RANDOM_ITEMS    = 1000;
    localparam int     HOLD_OFF_CYCLES = 300;
    localparam int     DRAIN_LIMIT     = 20000;
    localparam cmd_t   CMD_UNUSED      = 2'd3;
    localparam coord_t COORD_MAX       = 24'h7FFFFF;
    localparam coord_t COORD_MIN       = 24'h800000;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    cmd_t    command;
    id_t     landmark_id;
    coord_t  point_x;
    coord_t  point_y;
    logic    result_valid;
    logic    result_stall;
    id_t     nearest_id;
    logic    found;
    logic    load_overflow;

    // table model
    id_t         table_id [MAX_LANDMARKS];
    coord_t      table_x [MAX_LANDMARKS];
    coord_t      table_y [MAX_LANDMARKS];
    int unsigned table_count;

    result_t     pending_answers[$];
    int unsigned fail_count    = 0;
    bit          hold_off_req  = 1'b0;
    bit          no_idle       = 1'b0;

    nearest_landmark_associator #(
        .MAX_LANDMARKS (MAX_LANDMARKS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .command       (command),
        .landmark_id   (landmark_id),
        .point_x       (point_x),
        .point_y       (point_y),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .nearest_id    (nearest_id),
        .found         (found),
        .load_overflow (load_overflow)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // gap length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic coord_t coord_near(coord_t centre, int unsigned span);
        return coord_t'(int'(centre) + int'($urandom_range(0, 2 * span)) - int'(span));
    endfunction

    // nearest stored landmark by exact squared distance, first loaded wins ties
    function automatic result_t nearest_landmark(coord_t qx, coord_t qy);
        result_t          best;
        longint           dx;
        longint           dy;
        longint unsigned  sq_dist;
        longint unsigned  best_dist;
        best      = '0;
        best_dist = 0;
        for (int i = 0; i < table_count; i++)
        begin
            dx      = longint'(qx) - longint'(table_x[i]);
            dy      = longint'(qy) - longint'(table_y[i]);
            sq_dist = dx * dx + dy * dy;
            if (!best.found || sq_dist < best_dist)
            begin
                best.found      = 1'b1;
                best.nearest_id = table_id[i];
                best_dist       = sq_dist;
            end
        end
        return best;
    endfunction

    // update the table model and queue the answer the item causes
    function automatic void apply_command(cmd_t cmd, id_t id, coord_t x, coord_t y);
        result_t answer;
        answer = '0;
        case (cmd)
            CMD_CLEAR:
                table_count = 0;
            CMD_LOAD:
            begin
                if (table_count >= MAX_LANDMARKS)
                    answer.load_overflow = 1'b1;
                else
                begin
                    table_id[table_count] = id;
                    table_x[table_count]  = x;
                    table_y[table_count]  = y;
                    table_count++;
                end
                pending_answers.insert(pending_answers.size(), answer);
            end
            CMD_QUERY:
                pending_answers.insert(pending_answers.size(), nearest_landmark(x, y));
            default:
                ;
        endcase
    endfunction

    // offer one item and wait for it to be taken
    task automatic send_item(input cmd_t cmd, input id_t id, input coord_t x,
                             input coord_t y);
        int unsigned gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid  <= 1'b1;
        command     <= cmd;
        landmark_id <= id;
        point_x     <= x;
        point_y     <= y;
        do
            @(posedge clk);
        while (item_stall);
        apply_command(cmd, id, x, y);
    endtask

    // result side stalls, with a long hold-off on request
    initial
    begin : result_stall_driver
        int unsigned run;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                result_stall <= 1'b0;
                hold_off_req = 1'b0;
            end
            else
            begin
                run = no_idle ? 0 : pick_gap();
                result_stall <= (run != 0);
                if (run == 0)
                    run = $urandom_range(1, 12);
                repeat (run - 1) @(posedge clk);
            end
        end
    end

    // compare each accepted result with the oldest pending answer
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("unexpected result: nearest_id %0h found %0b load_overflow %0b",
                       nearest_id, found, load_overflow);
                fail_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (nearest_id !== want.nearest_id)
                begin
                    $error("nearest_id: expected %0h, got %0h", want.nearest_id, nearest_id);
                    fail_count++;
                end
                if (found !== want.found)
                begin
                    $error("found: expected %0b, got %0b", want.found, found);
                    fail_count++;
                end
                if (load_overflow !== want.load_overflow)
                begin
                    $error("load_overflow: expected %0b, got %0b",
                           want.load_overflow, load_overflow);
                    fail_count++;
                end
            end
        end
    end

    // field extremes, ties, empty table, unused command
    task automatic test_directed_extremes();
        send_item(CMD_QUERY, 16'h0000, 24'h000000, 24'h000000);
        send_item(CMD_UNUSED, 16'hFFFF, COORD_MAX, COORD_MIN);
        send_item(CMD_LOAD, 16'hFFFF, COORD_MAX, COORD_MAX);
        send_item(CMD_LOAD, 16'h0000, COORD_MIN, COORD_MIN);
        send_item(CMD_QUERY, 16'hFFFF, COORD_MIN, COORD_MIN);
        send_item(CMD_QUERY, 16'h0000, COORD_MAX, COORD_MAX);
        // equal distance to both corners
        send_item(CMD_QUERY, 16'h0000, COORD_MAX, COORD_MIN);
        send_item(CMD_QUERY, 16'h0000, COORD_MIN, COORD_MAX);
        // two landmarks on the same spot
        send_item(CMD_LOAD, 16'h5A5A, 24'h000000, 24'h000000);
        send_item(CMD_LOAD, 16'hA5A5, 24'h000000, 24'h000000);
        send_item(CMD_QUERY, 16'h0000, 24'h000000, 24'h000000);
        send_item(CMD_QUERY, 16'h0000, 24'hFFFFFF, 24'hFFFFFF);
        send_item(CMD_UNUSED, 16'h0000, 24'h000000, 24'h000000);
        send_item(CMD_QUERY, 16'h0000, 24'h000001, 24'h000001);
        send_item(CMD_LOAD, 16'h1234, 24'h000100, 24'hFFFF00);
        send_item(CMD_QUERY, 16'h0000, 24'h0000C8, 24'hFFFF38);
        send_item(CMD_CLEAR, 16'hFFFF, COORD_MAX, COORD_MAX);
        send_item(CMD_QUERY, 16'h0000, COORD_MAX, COORD_MAX);
        send_item(CMD_UNUSED, 16'h0000, COORD_MIN, COORD_MIN);
        send_item(CMD_LOAD, 16'h0001, COORD_MIN, COORD_MAX);
        send_item(CMD_QUERY, 16'h0000, COORD_MAX, COORD_MIN);
    endtask

    // fill the table, then loads beyond it are dropped
    task automatic test_table_full();
        send_item(CMD_CLEAR, 16'h0000, 24'h000000, 24'h000000);
        for (int i = 0; i < MAX_LANDMARKS; i++)
            send_item(CMD_LOAD, id_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()));
        send_item(CMD_LOAD, id_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()));
        send_item(CMD_LOAD, 16'hBEEF, table_x[0], table_y[0]);
        send_item(CMD_QUERY, 16'h0000, table_x[MAX_LANDMARKS-1], table_y[MAX_LANDMARKS-1]);
        send_item(CMD_QUERY, 16'h0000, table_x[0], table_y[0]);
        send_item(CMD_QUERY, 16'h0000, coord_t'($urandom()), coord_t'($urandom()));
        send_item(CMD_CLEAR, 16'h0000, 24'h000000, 24'h000000);
        send_item(CMD_LOAD, 16'h0042, 24'h000010, 24'hFFFFF0);
        send_item(CMD_QUERY, 16'h0000, coord_t'($urandom()), coord_t'($urandom()));
    endtask

    // long output hold-off while loads and queries keep coming
    task automatic test_back_pressure();
        send_item(CMD_CLEAR, 16'h0000, 24'h000000, 24'h000000);
        hold_off_req = 1'b1;
        for (int i = 0; i < 14; i++)
        begin
            if (i % 4 == 3)
                send_item(CMD_QUERY, 16'h0000, coord_t'($urandom()), coord_t'($urandom()));
            else
                send_item(CMD_LOAD, id_t'($urandom()), coord_t'($urandom()),
                          coord_t'($urandom()));
        end
        item_valid <= 1'b0;
        wait (!hold_off_req);
        @(posedge clk);
    endtask

    // landmark sets with queries around them, mixed with noise
    task automatic test_random_sequences();
        int unsigned sent;
        int unsigned roll;
        int unsigned set_size;
        int unsigned span;
        int unsigned pick;
        coord_t      centre;
        coord_t      x;
        coord_t      y;
        cmd_t        cmd;
        sent = 0;
        x    = '0;
        y    = '0;
        while (sent < RANDOM_ITEMS)
        begin
            // a stretch with no gaps on either side
            no_idle = (sent > RANDOM_ITEMS / 3) && (sent < RANDOM_ITEMS / 2);
            roll    = $urandom_range(0, 99);
            if (roll < 80)
            begin
                roll     = $urandom_range(0, 99);
                set_size = (roll < 70) ? $urandom_range(1, 8) :
                           (roll < 92) ? $urandom_range(9, 40) : $urandom_range(60, 70);
                roll     = $urandom_range(0, 2);
                span     = (roll == 0) ? 64 : (roll == 1) ? 4096 : (1 << 23);
                centre   = coord_t'($urandom());
                send_item(CMD_CLEAR, id_t'($urandom()), coord_t'($urandom()),
                          coord_t'($urandom()));
                sent++;
                // loads, some repeating the previous spot
                for (int i = 0; i < set_size; i++)
                begin
                    if (i == 0 || $urandom_range(0, 4) != 0)
                    begin
                        x = coord_near(centre, span);
                        y = coord_near(centre, span);
                    end
                    send_item(CMD_LOAD, id_t'($urandom()), x, y);
                    sent++;
                end
                // queries on, near or away from stored landmarks
                repeat ($urandom_range(1, 5))
                begin
                    roll = $urandom_range(0, 3);
                    pick = $urandom_range(0, table_count - 1);
                    if (roll == 0)
                    begin
                        x = table_x[pick];
                        y = table_y[pick];
                    end
                    else if (roll == 1)
                    begin
                        x = coord_near(table_x[pick], span >> 3);
                        y = coord_near(table_y[pick], span >> 3);
                    end
                    else
                    begin
                        x = coord_near(centre, span);
                        y = coord_near(centre, span);
                    end
                    send_item(CMD_QUERY, id_t'($urandom()), x, y);
                    sent++;
                end
            end
            else
            begin
                // noise over the whole command and field ranges
                repeat ($urandom_range(1, 6))
                begin
                    cmd = cmd_t'($urandom_range(0, 3));
                    send_item(cmd, id_t'($urandom()), coord_t'($urandom()),
                              coord_t'($urandom()));
                    if (cmd != CMD_UNUSED)
                        sent++;
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // run limit
    initial
    begin : run_limit
        #8ms;
        $display("nearest_landmark_associator: mismatch");
        $finish;
    end

    // test sequence
    initial
    begin : test_sequence
        int unsigned drain;
        table_count = 0;
        rst_n       = 1'b0;
        item_valid  = 1'b0;
        command     = CMD_CLEAR;
        landmark_id = '0;
        point_x     = '0;
        point_y     = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_table_full();
        test_back_pressure();
        test_random_sequences();

        item_valid <= 1'b0;
        drain = 0;
        while (pending_answers.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (MAX_LANDMARKS + 8) @(posedge clk);
        if (pending_answers.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_answers.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("nearest_landmark_associator: match");
        else
            $display("nearest_landmark_associator: mismatch");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/nla_pkg.sv
rtl/core/nla_cell.sv
rtl/core/nla_dist.sv
rtl/core/nearest_landmark_associator.sv
rtl/core/nla_checker.sv
tb/nearest_landmark_associator_tb.sv
